### hw/rtl/mm3_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mm3_pkg
// shared types and constants of the streaming murmur3 x86 32-bit hash
// ----------------------------------------------------------------------------
package mm3_pkg;

  // block scramble and hash update constants
  localparam logic [31:0] C1   = 32'hcc9e2d51;
  localparam logic [31:0] C2   = 32'h1b873593;
  localparam logic [31:0] HADD = 32'he6546b64;
  // final mix constants
  localparam logic [31:0] F1   = 32'h85ebca6b;
  localparam logic [31:0] F2   = 32'hc2b2ae35;

  // rotate amounts
  localparam int unsigned ROT_K = 15;
  localparam int unsigned ROT_H = 13;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_UPD,
    S_FIN1,
    S_FIN2,
    S_FIN3
  } mm3_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic upd;
    logic fin1;
    logic fin2;
    logic fin3;
  } mm3_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic last;
    logic out_free;
  } mm3_stat_t;

endpackage
`default_nettype wire

### hw/rtl/mm3_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mm3_ctrl
// sequencer: walks one item through scramble and update steps, and the last item also through final mix steps
// ----------------------------------------------------------------------------
module mm3_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire mm3_pkg::mm3_stat_t stat,
  output mm3_pkg::mm3_cmd_t    cmd
);

  mm3_pkg::mm3_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mm3_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      mm3_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = mm3_pkg::S_MUL1;
        end
      end
      mm3_pkg::S_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = mm3_pkg::S_MUL2;
      end
      mm3_pkg::S_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = mm3_pkg::S_UPD;
      end
      mm3_pkg::S_UPD: begin
        cmd.upd    = 1'b1;
        state_next = stat.last ? mm3_pkg::S_FIN1 : mm3_pkg::S_IDLE;
      end
      mm3_pkg::S_FIN1: begin
        cmd.fin1   = 1'b1;
        state_next = mm3_pkg::S_FIN2;
      end
      mm3_pkg::S_FIN2: begin
        cmd.fin2   = 1'b1;
        state_next = mm3_pkg::S_FIN3;
      end
      mm3_pkg::S_FIN3: begin
        // wait here while the output register still holds an untaken item
        if (stat.out_free) begin
          cmd.fin3   = 1'b1;
          state_next = mm3_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = mm3_pkg::S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### hw/rtl/mm3_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mm3_dp
// datapath: seed, running hash, length, shared multiplier and output register
// ----------------------------------------------------------------------------
module mm3_dp (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  cfg_we,
  input  wire  [31:0]          cfg_data,
  input  wire  [31:0]          block_data,
  input  wire  [2:0]           valid_bytes,
  input  wire                  last_block,
  input  wire mm3_pkg::mm3_cmd_t cmd,
  output mm3_pkg::mm3_stat_t   stat,
  output logic                 out_valid,
  input  wire                  out_stall,
  output logic [31:0]          hash_value
);

  logic [31:0] seed;
  logic        in_message;
  logic [31:0] run_hash;
  logic [31:0] byte_len;
  logic [31:0] blk_k;
  logic        blk_full;
  logic        blk_nz;
  logic        blk_last;
  logic [31:0] prod;

  logic [2:0]  cnt;
  logic [31:0] mask;
  logic [31:0] base_len;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [31:0] mul_y;
  logic [31:0] h_x;
  logic [31:0] h_r;
  logic [31:0] h_new;
  logic [31:0] f_in;

  // clamp count to four and mask bytes above it
  always_comb begin
    cnt = valid_bytes[2] ? 3'd4 : valid_bytes;
    case (cnt)
      3'd0:    mask = 32'h0000_0000;
      3'd1:    mask = 32'h0000_00ff;
      3'd2:    mask = 32'h0000_ffff;
      3'd3:    mask = 32'h00ff_ffff;
      default: mask = 32'hffff_ffff;
    endcase
    base_len = in_message ? byte_len : 32'd0;
  end

  // shared multiplier operand select
  always_comb begin
    f_in  = run_hash ^ byte_len;
    mul_a = blk_k;
    mul_b = mm3_pkg::C1;
    if (cmd.mul2) begin
      mul_a = {prod[31-mm3_pkg::ROT_K:0], prod[31:32-mm3_pkg::ROT_K]};
      mul_b = mm3_pkg::C2;
    end else if (cmd.fin1) begin
      mul_a = f_in ^ {16'd0, f_in[31:16]};
      mul_b = mm3_pkg::F1;
    end else if (cmd.fin2) begin
      mul_a = prod ^ {13'd0, prod[31:13]};
      mul_b = mm3_pkg::F2;
    end
    mul_y = mul_a * mul_b;
  end

  // hash update: xor scrambled block, then for a full block rotate, times five, add
  always_comb begin
    h_x   = run_hash ^ (blk_nz ? prod : 32'd0);
    h_r   = {h_x[31-mm3_pkg::ROT_H:0], h_x[31:32-mm3_pkg::ROT_H]};
    h_new = blk_full ? ((h_r + {h_r[29:0], 2'b00}) + mm3_pkg::HADD) : h_x;
  end

  // seed register
  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= 32'd0;
    end else if (cfg_we) begin
      seed <= cfg_data;
    end
  end

  // message state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_message <= 1'b0;
      byte_len   <= 32'd0;
      run_hash   <= 32'd0;
    end else begin
      if (cmd.load) begin
        in_message <= 1'b1;
        byte_len   <= base_len + {29'd0, cnt};
        if (!in_message) begin
          run_hash <= seed;
        end
      end
      if (cmd.upd) begin
        run_hash <= h_new;
        if (blk_last) begin
          in_message <= 1'b0;
        end
      end
    end
  end

  // captured item and multiplier result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      blk_k    <= block_data & mask;
      blk_full <= valid_bytes[2];
      blk_nz   <= (cnt != 3'd0);
      blk_last <= last_block | ~valid_bytes[2];
    end
    if (cmd.mul1 | cmd.mul2 | cmd.fin1 | cmd.fin2) begin
      prod <= mul_y;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.fin3) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin3) begin
      hash_value <= prod ^ {16'd0, prod[31:16]};
    end
  end

  // status
  always_comb begin
    stat.last     = blk_last;
    stat.out_free = ~out_valid | ~out_stall;
  end

endmodule
`default_nettype wire

### hw/rtl/murmur3_32_stream_hash.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// murmur3_32_stream_hash
// streaming murmur3 x86 32-bit hash, one 32-bit block per item
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------
//  in       | in_valid / in_stall  | block_data, valid_bytes, last_block
//  out      | out_valid / out_stall| hash_value
//  cfg      | cfg_we               | cfg_data (seed)
//
//  an item that does not end the message passes accept, two scramble
//  multiplies and hash update; one that ends it adds the final-mix
//  multiplies on the one shared multiplier and the output load
//  a finished hash sits in the output register while the next item is taken
//  reset clears the seed, the message state and the output valid
//  a stalled output holds the last final-mix step until the register frees
// ----------------------------------------------------------------------------
module murmur3_32_stream_hash (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_we,
  input  wire  [31:0] cfg_data,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [31:0] block_data,
  input  wire  [2:0]  valid_bytes,
  input  wire         last_block,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [31:0] hash_value
);

  mm3_pkg::mm3_cmd_t  cmd;
  mm3_pkg::mm3_stat_t stat;

  // sequencer
  mm3_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath
  mm3_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .block_data  (block_data),
    .valid_bytes (valid_bytes),
    .last_block  (last_block),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .hash_value  (hash_value)
  );

endmodule
`default_nettype wire

### hw/rtl/mm3_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mm3_checker
// port-level checks of the murmur3 stream hash, bound to the top level
// ----------------------------------------------------------------------------
module mm3_checker (
  input wire        clk,
  input wire        rst,
  input wire        in_valid,
  input wire        in_stall,
  input wire        out_valid,
  input wire        out_stall,
  input wire [31:0] hash_value
);

  // a stalled result item stays offered
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result item dropped while stalled");

  // a stalled result item keeps its value
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(hash_value))
    else $error("result item changed while stalled");

  // the block is busy in the cycle after it takes an item
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("item taken while previous item still at work");

  // no new result can appear right after an item is taken
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !$rose(out_valid) ##1 !$rose(out_valid))
    else $error("result appeared too early after an item");

endmodule

bind murmur3_32_stream_hash mm3_checker u_mm3_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .hash_value (hash_value)
);
`default_nettype wire
